>>> sv/xcpd_pkg.sv
// ----------------------------------------------------------------------------
// xcpd_pkg
// Shared types and constants of the packet deframer: frame kinds, status
// codes, configuration register indexes and the type classifier.
// ----------------------------------------------------------------------------
package xcpd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 16;
  localparam int unsigned CfgIdxW = 3;

  // Longest payload accepted; a longer length aborts the packet.
  localparam logic [LenW-1:0] MaxPayload = LenW'(1020);

  typedef enum logic [1:0] {
    KindControl = 2'd0,
    KindChannel = 2'd1,
    KindSpeech  = 2'd2,
    KindUnknown = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    StatusOk      = 2'd0,
    StatusBadChk  = 2'd1,
    StatusUnknown = 2'd2,
    StatusTooLong = 2'd3
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgStartMarker  = 3'd0,
    CfgParityMarker = 3'd1,
    CfgTypeControl  = 3'd2,
    CfgTypeChannel  = 3'd3,
    CfgTypeSpeech   = 3'd4
  } cfg_idx_e;

  // Control wins over speech, speech over channel data.
  function automatic kind_e classify(input logic [ByteW-1:0] t,
                                     input logic [ByteW-1:0] code_control,
                                     input logic [ByteW-1:0] code_channel,
                                     input logic [ByteW-1:0] code_speech);
    kind_e k;
    priority if (t == code_control) begin
      k = KindControl;
    end else if (t == code_speech) begin
      k = KindSpeech;
    end else if (t == code_channel) begin
      k = KindChannel;
    end else begin
      k = KindUnknown;
    end
    return k;
  endfunction

endpackage

>>> sv/xcpd_rx_if.sv
// ----------------------------------------------------------------------------
// xcpd_rx_if
// Received byte channel: valid/ready handshake carrying one link byte.
// ----------------------------------------------------------------------------
interface xcpd_rx_if import xcpd_pkg::*; ();

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);

endinterface

>>> sv/xcpd_res_if.sv
// ----------------------------------------------------------------------------
// xcpd_res_if
// Result channel: valid/ready handshake carrying a payload byte and the
// packet end status.
// ----------------------------------------------------------------------------
interface xcpd_res_if import xcpd_pkg::*; ();

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic             data_valid;
  logic             frame_last;
  status_e          frame_status;
  kind_e            frame_kind;
  logic             had_checksum;

  modport source (output valid, output data_byte, output data_valid,
                  output frame_last, output frame_status, output frame_kind,
                  output had_checksum, input ready);
  modport sink   (input valid, input data_byte, input data_valid,
                  input frame_last, input frame_status, input frame_kind,
                  input had_checksum, output ready);

endinterface

>>> sv/xor_checked_packet_deframer_core.sv
// ----------------------------------------------------------------------------
// xor_checked_packet_deframer_core
// Deframes length-prefixed packets from a serial byte stream and checks
// their XOR checksum.
// ----------------------------------------------------------------------------
// Usage:
//   rx_i  takes one link byte per request. Outside a packet, bytes other
//         than the start marker are dropped without a result.
//   res_o gives at most one result per byte: each payload byte with
//         data_valid set, frame_last on the byte that ends a packet (or on
//         the header byte that ends an empty or over-long packet), together
//         with status, kind and whether a checksum field was checked.
//   cfg_* writes the marker and type code registers; write them only while
//         the block is idle.
// Timing: one byte per cycle sustained. A result appears on res_o the cycle
//   after its byte is taken; the decode is a compare, a 16-bit decrement and
//   an XOR between the state registers and the single result register.
// Stall: while a result waits with res_o.ready low, rx_i.ready drops; the
//   result register is the only buffer, so a byte is taken in the same
//   cycle the waiting result leaves.
// Reset: phase returns to hunting, no result is pending and the registers
//   take their default markers and type codes.
// ----------------------------------------------------------------------------
module xor_checked_packet_deframer_core import xcpd_pkg::*; #(
  parameter logic [LenW-1:0] MaxLen = MaxPayload
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  xcpd_rx_if.sink            rx_i,
  xcpd_res_if.source         res_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [ByteW-1:0]   cfg_wdata_i
);

  typedef enum logic [4:0] {
    PhHunt  = 5'b00001,
    PhLenHi = 5'b00010,
    PhLenLo = 5'b00100,
    PhType  = 5'b01000,
    PhData  = 5'b10000
  } phase_e;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             data_valid;
    logic             frame_last;
    status_e          frame_status;
    kind_e            frame_kind;
    logic             had_checksum;
  } res_t;

  // Configuration registers
  logic [ByteW-1:0] start_marker_q, parity_marker_q;
  logic [ByteW-1:0] code_control_q, code_channel_q, code_speech_q;

  // Frame state
  phase_e           phase_q, phase_d;
  logic [LenW-1:0]  len_q, len_d;
  logic [LenW-1:0]  left_q, left_d;
  logic [ByteW-1:0] xor_q, xor_d;
  logic [ByteW-1:0] prev_q, prev_d;
  kind_e            kind_q, kind_d;

  // Result register
  logic             res_valid_q;
  res_t             res_q, res_d;
  logic             emit;

  logic             rx_fire;
  logic [ByteW-1:0] b;
  logic [LenW-1:0]  left_dec;
  kind_e            kind_new;

  assign rx_i.ready = !res_valid_q || res_o.ready;
  assign rx_fire    = rx_i.valid && rx_i.ready;
  assign b          = rx_i.rx_byte;
  assign left_dec   = left_q - LenW'(1);
  assign kind_new   = classify(b, code_control_q, code_channel_q, code_speech_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_marker_q  <= ByteW'(97);
      parity_marker_q <= ByteW'(47);
      code_control_q  <= ByteW'(0);
      code_channel_q  <= ByteW'(1);
      code_speech_q   <= ByteW'(2);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgStartMarker:  start_marker_q  <= cfg_wdata_i;
        CfgParityMarker: parity_marker_q <= cfg_wdata_i;
        CfgTypeControl:  code_control_q  <= cfg_wdata_i;
        CfgTypeChannel:  code_channel_q  <= cfg_wdata_i;
        CfgTypeSpeech:   code_speech_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_d = phase_q;
    len_d   = len_q;
    left_d  = left_q;
    xor_d   = xor_q;
    prev_d  = prev_q;
    kind_d  = kind_q;
    emit    = 1'b0;
    res_d   = '{data_byte: '0, data_valid: 1'b0, frame_last: 1'b0,
                frame_status: StatusOk, frame_kind: KindControl,
                had_checksum: 1'b0};

    unique case (phase_q)
      PhLenHi: begin
        len_d   = {b, ByteW'(0)};
        xor_d   = b;
        phase_d = PhLenLo;
      end
      PhLenLo: begin
        len_d = {len_q[LenW-1:ByteW], b};
        xor_d = xor_q ^ b;
        if (len_d > MaxLen) begin
          // abort: type is not known yet
          phase_d            = PhHunt;
          emit               = 1'b1;
          res_d.frame_last   = 1'b1;
          res_d.frame_status = StatusTooLong;
          res_d.frame_kind   = KindUnknown;
        end else begin
          phase_d = PhType;
        end
      end
      PhType: begin
        xor_d  = xor_q ^ b;
        kind_d = kind_new;
        if (len_q == '0) begin
          phase_d            = PhHunt;
          emit               = 1'b1;
          res_d.frame_last   = 1'b1;
          res_d.frame_kind   = kind_new;
          res_d.frame_status = (kind_new == KindUnknown) ? StatusUnknown : StatusOk;
        end else begin
          left_d  = len_q;
          prev_d  = '0;
          phase_d = PhData;
        end
      end
      PhData: begin
        left_d           = left_dec;
        emit             = 1'b1;
        res_d.data_byte  = b;
        res_d.data_valid = 1'b1;
        res_d.frame_kind = kind_q;
        if (left_dec == '0) begin
          phase_d          = PhHunt;
          res_d.frame_last = 1'b1;
          if (kind_q == KindUnknown) begin
            res_d.frame_status = StatusUnknown;
          end else if (len_q >= LenW'(2) && prev_q == parity_marker_q) begin
            // last byte is the checksum
            res_d.had_checksum = 1'b1;
            res_d.frame_status = (b != xor_q) ? StatusBadChk : StatusOk;
          end
        end else begin
          xor_d  = xor_q ^ b;
          prev_d = b;
        end
      end
      default: begin
        // hunting, and any stray phase code
        phase_d = (b == start_marker_q) ? PhLenHi : PhHunt;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt;
      len_q   <= '0;
      left_q  <= '0;
      xor_q   <= '0;
      prev_q  <= '0;
      kind_q  <= KindControl;
    end else if (rx_fire) begin
      phase_q <= phase_d;
      len_q   <= len_d;
      left_q  <= left_d;
      xor_q   <= xor_d;
      prev_q  <= prev_d;
      kind_q  <= kind_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (rx_fire) begin
      res_valid_q <= emit;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  // Load on every taken byte; the old result has left by then.
  always_ff @(posedge clk_i) begin
    if (rx_fire) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.data_byte    = res_q.data_byte;
  assign res_o.data_valid   = res_q.data_valid;
  assign res_o.frame_last   = res_q.frame_last;
  assign res_o.frame_status = res_q.frame_status;
  assign res_o.frame_kind   = res_q.frame_kind;
  assign res_o.had_checksum = res_q.had_checksum;

  // A checksum is only reported on the last payload byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.had_checksum |-> res_q.frame_last && res_q.data_valid)
    else $error("checksum flag outside packet end");

  // Unknown status only comes with an unknown kind.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.frame_status == StatusUnknown |->
      res_q.frame_kind == KindUnknown && res_q.frame_last)
    else $error("unknown status with a known kind");

  // The payload counter never runs dry while in the data phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhData |-> left_q != '0)
    else $error("data phase with no bytes left");

  // A byte taken while hunting never makes a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_fire && phase_q == PhHunt |=> !res_valid_q)
    else $error("result produced while hunting");

endmodule

>>> test/tb_xor_checked_packet_deframer_core.sv
// ----------------------------------------------------------------------------
// tb_xor_checked_packet_deframer_core
// Self-checking bench for the packet deframer. A directed table covers header,
// length, type and checksum corners. Random packet streams then run under three
// further register settings with varied handshake pressure. Every result is
// scored against an in-bench model of the deframer or an expectation written in the table.
// ----------------------------------------------------------------------------
module tb_xor_checked_packet_deframer_core import xcpd_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HalfPeriod     = 2;
  localparam int unsigned ResetCycles    = 3;
  localparam int unsigned SettleCycles   = 4;
  localparam int unsigned HoldOffCycles  = 300;
  localparam int unsigned WatchdogLimit  = 5000;
  localparam int unsigned PhaseBytes     = 90;
  localparam int unsigned MaxReports     = 100;
  localparam int unsigned NumDirected    = 26;

  typedef enum logic [2:0] {
    PhHunt,
    PhLenHi,
    PhLenLo,
    PhType,
    PhPayload
  } deframe_phase_e;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             data_valid;
    logic             frame_last;
    status_e          frame_status;
    kind_e            frame_kind;
    logic             had_checksum;
  } frame_res_t;

  typedef struct packed {
    logic [ByteW-1:0] rx_byte;
    logic             fixed;      // expectation written out in the table
    logic             fixed_has;
    frame_res_t       fixed_res;
  } table_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [ByteW-1:0]   cfg_wdata_i;

  xcpd_rx_if  rx_ch ();
  xcpd_res_if res_ch ();

  xor_checked_packet_deframer_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_i        (rx_ch),
    .res_o       (res_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #HalfPeriod clk_i = ~clk_i;

  // Register copies and deframing state of the bench model
  logic [ByteW-1:0] deframer_regs [5];
  deframe_phase_e   trk_phase;
  logic [LenW-1:0]  trk_len;
  logic [LenW-1:0]  trk_left;
  logic [ByteW-1:0] trk_xor;
  logic [ByteW-1:0] trk_prev;
  kind_e            trk_kind;

  frame_res_t  deframed_q [$];
  table_row_t  dir_rows [NumDirected];

  int unsigned mismatch_count = 0;
  int unsigned bytes_fed      = 0;
  int unsigned results_seen   = 0;
  int unsigned end_tally [4]  = '{default: 0};
  int unsigned stall_cycles   = 0;

  int unsigned src_idle_pct  = 0;
  int unsigned sink_idle_pct = 0;
  int unsigned src_quiet     = 0;
  int unsigned sink_quiet    = 0;
  int unsigned sink_hold     = 0;
  int unsigned hold_asks     = 0;
  int unsigned hold_seen     = 0;

  task automatic report_mismatch(input string what);
    if (mismatch_count < MaxReports) begin
      $display("MISMATCH @%0t: %s", $time, what);
    end
    mismatch_count++;
  endtask

  task automatic check_field(input string fname, input int unsigned got,
                             input int unsigned want);
    if (got != want) begin
      report_mismatch($sformatf("%s got %0h, wanted %0h", fname, got, want));
    end
  endtask

  // Advance the model by one link byte; returns 1 when a result is due.
  function automatic bit deframe_step(input logic [ByteW-1:0] b, output frame_res_t r);
    bit produced;
    produced = 1'b0;
    r = '0;
    case (trk_phase)
      PhLenHi: begin
        trk_len   = {b, 8'h00};
        trk_xor   = b;
        trk_phase = PhLenLo;
      end
      PhLenLo: begin
        trk_len[7:0] = b;
        trk_xor      = trk_xor ^ b;
        if (trk_len > MaxPayload) begin
          trk_phase      = PhHunt;
          r.frame_last   = 1'b1;
          r.frame_status = StatusTooLong;
          r.frame_kind   = KindUnknown;
          produced       = 1'b1;
        end else begin
          trk_phase = PhType;
        end
      end
      PhType: begin
        trk_xor = trk_xor ^ b;
        if (b == deframer_regs[CfgTypeControl]) begin
          trk_kind = KindControl;
        end else if (b == deframer_regs[CfgTypeSpeech]) begin
          trk_kind = KindSpeech;
        end else if (b == deframer_regs[CfgTypeChannel]) begin
          trk_kind = KindChannel;
        end else begin
          trk_kind = KindUnknown;
        end
        if (trk_len == '0) begin
          trk_phase    = PhHunt;
          r.frame_last = 1'b1;
          r.frame_kind = trk_kind;
          if (trk_kind == KindUnknown) begin
            r.frame_status = StatusUnknown;
          end
          produced = 1'b1;
        end else begin
          trk_left  = trk_len;
          trk_prev  = '0;
          trk_phase = PhPayload;
        end
      end
      PhPayload: begin
        trk_left     = trk_left - 1'b1;
        r.data_byte  = b;
        r.data_valid = 1'b1;
        r.frame_kind = trk_kind;
        produced     = 1'b1;
        if (trk_left == '0) begin
          r.frame_last = 1'b1;
          trk_phase    = PhHunt;
          if (trk_kind == KindUnknown) begin
            r.frame_status = StatusUnknown;
          end else if (trk_len >= 2 && trk_prev == deframer_regs[CfgParityMarker]) begin
            r.had_checksum = 1'b1;
            if (b != trk_xor) begin
              r.frame_status = StatusBadChk;
            end
          end
        end else begin
          trk_xor  = trk_xor ^ b;
          trk_prev = b;
        end
      end
      default: begin
        if (b == deframer_regs[CfgStartMarker]) begin
          trk_phase = PhLenHi;
        end else begin
          trk_phase = PhHunt;
        end
      end
    endcase
    return produced;
  endfunction

  function automatic table_row_t plain_row(input logic [ByteW-1:0] b);
    table_row_t row;
    row = '0;
    row.rx_byte = b;
    return row;
  endfunction

  function automatic table_row_t silent_row(input logic [ByteW-1:0] b);
    table_row_t row;
    row = plain_row(b);
    row.fixed = 1'b1;
    return row;
  endfunction

  function automatic table_row_t end_row(input logic [ByteW-1:0] b, input logic dv,
                                         input status_e s, input kind_e k,
                                         input logic chk);
    table_row_t row;
    row = silent_row(b);
    row.fixed_has              = 1'b1;
    row.fixed_res.data_byte    = dv ? b : '0;
    row.fixed_res.data_valid   = dv;
    row.fixed_res.frame_last   = 1'b1;
    row.fixed_res.frame_status = s;
    row.fixed_res.frame_kind   = k;
    row.fixed_res.had_checksum = chk;
    return row;
  endfunction

  // Offer one byte and hold it until the block takes it.
  task automatic put_byte(input logic [ByteW-1:0] b);
    while (src_quiet == 0 && $urandom_range(99) < src_idle_pct) begin
      rx_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    if (src_quiet != 0) begin
      src_quiet--;
    end else if ($urandom_range(99) < 2) begin
      src_quiet = 40;
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    @(posedge clk_i);
    while (!rx_ch.ready) @(posedge clk_i);
  endtask

  task automatic feed_byte(input logic [ByteW-1:0] b, input bit counts);
    frame_res_t r;
    put_byte(b);
    if (deframe_step(b, r)) begin
      deframed_q.push_back(r);
    end
    if (counts) begin
      bytes_fed++;
    end
  endtask

  task automatic send_frame(input int unsigned len, input logic [ByteW-1:0] tcode,
                            input bit with_chk, input bit good_chk);
    logic [ByteW-1:0] body [$];
    logic [ByteW-1:0] x;
    int unsigned      i;
    body = {};
    x = len[15:8] ^ len[7:0] ^ tcode;
    feed_byte(deframer_regs[CfgStartMarker], 1'b1);
    feed_byte(len[15:8], 1'b1);
    feed_byte(len[7:0], 1'b1);
    if (len > MaxPayload) begin
      return;
    end
    feed_byte(tcode, 1'b1);
    for (i = 0; i < len; i++) begin
      body.push_back(8'($urandom_range(255)));
    end
    if (with_chk && len >= 2) begin
      body[len-2] = deframer_regs[CfgParityMarker];
      for (i = 0; i < len - 1; i++) begin
        x = x ^ body[i];
      end
      body[len-1] = good_chk ? x : x ^ 8'($urandom_range(255, 1));
    end
    foreach (body[k]) begin
      feed_byte(body[k], 1'b1);
    end
  endtask

  task automatic send_random_frame();
    int unsigned      pick;
    int unsigned      n;
    int unsigned      len;
    logic [ByteW-1:0] tcode;
    pick = $urandom_range(99);
    case ($urandom_range(3))
      0:       tcode = deframer_regs[CfgTypeControl];
      1:       tcode = deframer_regs[CfgTypeChannel];
      2:       tcode = deframer_regs[CfgTypeSpeech];
      default: tcode = 8'($urandom_range(255));
    endcase
    if (pick < 8) begin
      n = $urandom_range(4, 1);
      repeat (n) feed_byte(8'($urandom_range(255)), 1'b0);
    end else if (pick < 13) begin
      send_frame($urandom_range(65535, MaxPayload + 1), tcode, 1'b0, 1'b0);
    end else if (pick < 20) begin
      // declared length disagrees with the bytes that follow
      feed_byte(deframer_regs[CfgStartMarker], 1'b1);
      feed_byte(8'h00, 1'b1);
      feed_byte(8'($urandom_range(6, 1)), 1'b1);
      feed_byte(tcode, 1'b1);
      n = $urandom_range(8);
      repeat (n) feed_byte(8'($urandom_range(255)), 1'b1);
    end else begin
      len = ($urandom_range(99) < 85) ? $urandom_range(12) : $urandom_range(64, 13);
      send_frame(len, tcode, 1'($urandom_range(1)), $urandom_range(99) < 75);
    end
  endtask

  // Finish any open packet, then hold the input until all results are in.
  task automatic drain_pending();
    while (trk_phase != PhHunt) begin
      feed_byte(~deframer_regs[CfgStartMarker], 1'b0);
    end
    rx_ch.valid <= 1'b0;
    while (deframed_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [ByteW-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    deframer_regs[idx] = v;
  endtask

  task automatic load_settings(input logic [ByteW-1:0] start_v, input logic [ByteW-1:0] par_v,
                               input logic [ByteW-1:0] ctl_v, input logic [ByteW-1:0] chan_v,
                               input logic [ByteW-1:0] sp_v);
    write_reg(CfgStartMarker, start_v);
    write_reg(CfgParityMarker, par_v);
    write_reg(CfgTypeControl, ctl_v);
    write_reg(CfgTypeChannel, chan_v);
    write_reg(CfgTypeSpeech, sp_v);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_random(input int unsigned target, input bit pause_midway,
                            input bit hold_midway);
    int unsigned goal;
    bit          midway_done;
    goal        = bytes_fed + target;
    midway_done = 1'b0;
    while (bytes_fed < goal) begin
      send_random_frame();
      if (!midway_done && bytes_fed >= goal - target / 2) begin
        midway_done = 1'b1;
        if (hold_midway) begin
          hold_asks++;
        end
        if (pause_midway) begin
          rx_ch.valid <= 1'b0;
          do @(posedge clk_i); while (deframed_q.size() != 0);
        end
      end
    end
  endtask

  // Result side: score each accepted result, then pick the next ready.
  always @(posedge clk_i) begin
    frame_res_t want;
    if (res_ch.valid && res_ch.ready) begin
      if (deframed_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result data=%0h last=%0b",
                                  res_ch.data_byte, res_ch.frame_last));
      end else begin
        want = deframed_q.pop_front();
        check_field("data_byte", res_ch.data_byte, want.data_byte);
        check_field("data_valid", res_ch.data_valid, want.data_valid);
        check_field("frame_last", res_ch.frame_last, want.frame_last);
        check_field("frame_status", res_ch.frame_status, want.frame_status);
        check_field("frame_kind", res_ch.frame_kind, want.frame_kind);
        check_field("had_checksum", res_ch.had_checksum, want.had_checksum);
        if (want.frame_last) begin
          end_tally[want.frame_status]++;
        end
        results_seen++;
      end
    end
    if (sink_hold != 0) begin
      sink_hold--;
      res_ch.ready <= 1'b0;
    end else if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      sink_hold = HoldOffCycles;
      res_ch.ready <= 1'b0;
    end else if (sink_quiet != 0) begin
      sink_quiet--;
      res_ch.ready <= 1'b1;
    end else begin
      if ($urandom_range(99) < 2) begin
        sink_quiet = 40;
      end
      res_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles == WatchdogLimit) begin
      $display("Watchdog: no request moved for %0d cycles, %0d results outstanding",
               WatchdogLimit, deframed_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    bit         got;
    frame_res_t r;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= '0;
    cfg_wdata_i   <= '0;
    rx_ch.valid   <= 1'b0;
    rx_ch.rx_byte <= '0;

    deframer_regs[CfgStartMarker]  = 8'd97;
    deframer_regs[CfgParityMarker] = 8'd47;
    deframer_regs[CfgTypeControl]  = 8'd0;
    deframer_regs[CfgTypeChannel]  = 8'd1;
    deframer_regs[CfgTypeSpeech]   = 8'd2;
    trk_phase = PhHunt;
    trk_len   = '0;
    trk_left  = '0;
    trk_xor   = '0;
    trk_prev  = '0;
    trk_kind  = KindControl;

    dir_rows = '{
      silent_row(8'h00),                                          // noise outside a packet
      plain_row(8'h61), plain_row(8'hFF),                         // longest length field
      end_row(8'hFF, 1'b0, StatusTooLong, KindUnknown, 1'b0),
      plain_row(8'h61), plain_row(8'h00), plain_row(8'h00),       // empty control packet
      end_row(8'h00, 1'b0, StatusOk, KindControl, 1'b0),
      plain_row(8'h61), plain_row(8'h00), plain_row(8'h03),       // channel, good checksum
      plain_row(8'h01), plain_row(8'h55), plain_row(8'h2F),
      end_row(8'h78, 1'b1, StatusOk, KindChannel, 1'b1),
      plain_row(8'h61), plain_row(8'h00), plain_row(8'h02),       // speech, bad checksum
      plain_row(8'h02), plain_row(8'h2F),
      end_row(8'h00, 1'b1, StatusBadChk, KindSpeech, 1'b1),
      plain_row(8'h61), plain_row(8'h00), plain_row(8'h01),       // unknown type, one byte
      plain_row(8'hFF),
      end_row(8'h00, 1'b1, StatusUnknown, KindUnknown, 1'b0)
    };

    src_idle_pct  = 25;
    sink_idle_pct = 87;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[n]) begin
      put_byte(dir_rows[n].rx_byte);
      got = deframe_step(dir_rows[n].rx_byte, r);
      if (!dir_rows[n].fixed) begin
        if (got) begin
          deframed_q.push_back(r);
        end
      end else if (dir_rows[n].fixed_has) begin
        deframed_q.push_back(dir_rows[n].fixed_res);
      end
      bytes_fed++;
    end
    drain_pending();

    load_settings(8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)));
    run_random(PhaseBytes, 1'b1, 1'b0);
    drain_pending();

    // channel and speech share a code: speech wins
    src_idle_pct  = 87;
    sink_idle_pct = 25;
    load_settings(8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF);
    run_random(PhaseBytes, 1'b0, 1'b0);
    drain_pending();

    // all type codes equal: control wins
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    load_settings(8'hFF, 8'h00, 8'h80, 8'h80, 8'h80);
    send_frame(MaxPayload + 1, deframer_regs[CfgTypeControl], 1'b0, 1'b0);
    send_frame(MaxPayload, deframer_regs[CfgTypeControl], 1'b1, 1'b1);
    run_random(PhaseBytes, 1'b0, 1'b1);
    drain_pending();

    $display("Fed %0d packet bytes and scored %0d results under four register settings",
             bytes_fed, results_seen);
    $display("Packet ends: %0d ok, %0d bad checksum, %0d unknown type, %0d too long",
             end_tally[StatusOk], end_tally[StatusBadChk], end_tally[StatusUnknown],
             end_tally[StatusTooLong]);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> xor_checked_packet_deframer_core.f
sv/xcpd_pkg.sv
sv/xcpd_rx_if.sv
sv/xcpd_res_if.sv
sv/xor_checked_packet_deframer_core.sv
test/tb_xor_checked_packet_deframer_core.sv
